[hw/rtl/thermistor_voltage_to_celsius_defines.svh]
// Assertion macros shared by the checker of the thermistor converter.
// No dependencies; include by bare file name.
`ifndef THERMISTOR_VOLTAGE_TO_CELSIUS_DEFINES_SVH
`define THERMISTOR_VOLTAGE_TO_CELSIUS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TVC_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TVC_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[hw/rtl/tvc_pkg.sv]
// Shared widths, constants, codes and types of the thermistor converter.
// No dependencies.
package tvc_pkg;

    localparam int V_W       = 19;
    localparam int BR_W      = 20;
    localparam int COEF_W    = 48;
    localparam int FRAC_W    = 48;
    localparam int R_W       = 63;
    localparam int R_FRAC    = 24;
    localparam int PROD_W    = 39;
    localparam int SH_W      = 6;
    localparam int MAG_W     = SH_W + FRAC_W;
    localparam int L_W       = 53;
    localparam int L2_W      = 58;
    localparam int L3_W      = 63;
    localparam int DATA_W    = 64;
    localparam int TEMP_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [FRAC_W-1:0] LN2_Q48     = 48'hB17217F7D1CF;
    localparam logic [DATA_W-1:0] HUNDRED_Q48 = 64'd100 << FRAC_W;

    localparam logic [TEMP_W-1:0]        KELVIN_CENTI = 16'd27315;
    localparam logic [TEMP_W-1:0]        TK_MAX       = 16'd60082;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX     = 16'sh7FFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN     = 16'sh954D;
    localparam logic signed [TEMP_W-1:0] TEMP_ZERO    = 16'sh0000;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_VOLTAGE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_RESISTANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C          = 3'd4;

    localparam logic [V_W-1:0]    BIAS_VOLTAGE_RESET    = 19'd327680;
    localparam logic [BR_W-1:0]   BIAS_RESISTANCE_RESET = 20'd10000;
    localparam logic [COEF_W-1:0] COEF_A_RESET          = 48'd316931253627;
    localparam logic [COEF_W-1:0] COEF_B_RESET          = 48'd66026377000;
    localparam logic [COEF_W-1:0] COEF_C_RESET          = 48'd24337140;

    typedef struct packed {
        logic valid;
        logic bad;
    } ctl_t;

endpackage

[hw/rtl/thermistor_voltage_to_celsius.sv]
// Thermistor divider voltage to temperature in hundredths of a degree Celsius
// using the Steinhart-Hart law. The block is a fully pipelined datapath that
// accepts one beat per clock cycle while the output is not stalled and returns
// one result beat for each, in order. Its stages include the 63-stage
// resistance divider, the LOG_ITERATIONS squaring stages of the logarithm, four
// levels of three-stage multipliers and the 16-stage reciprocal divider. A
// stall at the output freezes the whole pipeline, so no beat is lost or
// repeated. The user must write registers through the write port only while
// the pipeline is empty; the block itself does not enforce this.
module thermistor_voltage_to_celsius #(
    parameter int LOG_ITERATIONS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [tvc_pkg::V_W-1:0]            sense_voltage,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [tvc_pkg::TEMP_W-1:0]  temp_centi,
    output logic [tvc_pkg::STATUS_W-1:0]       status,
    input  logic                               cfg_we,
    input  logic [tvc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tvc_pkg::COEF_W-1:0]         cfg_data
);

    localparam int VW     = tvc_pkg::V_W;
    localparam int RW     = tvc_pkg::R_W;
    localparam int DW     = tvc_pkg::DATA_W;
    localparam int TW     = tvc_pkg::TEMP_W;
    localparam int WIDE_W = DW + TW;
    localparam int SIDE_S = 3;
    localparam int SIDE_L = SIDE_S + tvc_pkg::L_W;

    typedef struct packed {
        logic negd;
        logic dz;
        logic ovf;
    } fin_t;

    logic adv;

    logic [VW-1:0]            bias_voltage_reg;
    logic [tvc_pkg::BR_W-1:0] bias_resistance_reg;
    logic [tvc_pkg::COEF_W-1:0] coef_a_reg;
    logic [tvc_pkg::COEF_W-1:0] coef_b_reg;
    logic [tvc_pkg::COEF_W-1:0] coef_c_reg;

    tvc_pkg::ctl_t        s0_ctl_reg;
    logic [VW-1:0]        s0_v_reg;
    logic [VW-1:0]        s0_diff_reg;
    tvc_pkg::ctl_t        s1_ctl_reg;
    logic [VW-1:0]        s1_v_reg;
    logic [tvc_pkg::PROD_W-1:0] s1_prod_reg;

    logic [RW-1:0]        dv_work_reg [RW];
    logic [RW-1:0]        dv_work_next[RW];
    logic [VW-1:0]        dv_rem_reg  [RW];
    logic [VW-1:0]        dv_rem_next [RW];
    logic [VW-1:0]        dv_v_reg    [RW];
    tvc_pkg::ctl_t        dv_ctl_reg  [RW];

    tvc_pkg::ctl_t        lg_ctl_in;
    tvc_pkg::ctl_t        lg_ctl;
    logic                 lg_lneg;
    logic [tvc_pkg::MAG_W-1:0] lg_mag;

    logic [DW-1:0]        m1_prod;
    logic [SIDE_S-1:0]    m1_side;
    logic [DW-1:0]        m2_prod;
    logic [SIDE_S-1:0]    m2_side;
    logic [DW-1:0]        m3_prod;
    logic [tvc_pkg::L_W-1:0] m3_side;
    logic [DW-1:0]        m4_prod;
    logic [SIDE_L-1:0]    m4_side;
    logic [DW-1:0]        m5_prod;
    logic [SIDE_L-1:0]    m5_side;

    tvc_pkg::ctl_t        m5_ctl;
    logic                 m5_lneg;
    logic [DW-1:0]        sum_bc;
    logic [DW-1:0]        pos_next;
    logic [DW-1:0]        neg_next;
    tvc_pkg::ctl_t        sm_ctl_reg;
    logic [DW-1:0]        sm_d_reg;
    logic                 sm_negd_reg;

    tvc_pkg::ctl_t        q0_ctl_reg;
    logic [DW-1:0]        q0_n_reg;
    logic [DW-1:0]        q0_d_reg;
    fin_t                 q0_fin_reg;

    logic [DW-1:0]        qd_rem_reg [TW];
    logic [DW-1:0]        qd_rem_next[TW];
    logic [TW-1:0]        qd_q_reg   [TW];
    logic [TW-1:0]        qd_q_next  [TW];
    logic [DW-1:0]        qd_d_reg   [TW];
    fin_t                 qd_fin_reg [TW];
    tvc_pkg::ctl_t        qd_ctl_reg [TW];

    logic signed [TW-1:0]        temp_reg;
    logic signed [TW-1:0]        temp_next;
    logic [tvc_pkg::STATUS_W-1:0] status_reg;
    logic [tvc_pkg::STATUS_W-1:0] status_next;
    logic                        out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_voltage_reg    <= tvc_pkg::BIAS_VOLTAGE_RESET;
            bias_resistance_reg <= tvc_pkg::BIAS_RESISTANCE_RESET;
            coef_a_reg          <= tvc_pkg::COEF_A_RESET;
            coef_b_reg          <= tvc_pkg::COEF_B_RESET;
            coef_c_reg          <= tvc_pkg::COEF_C_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tvc_pkg::CFG_BIAS_VOLTAGE:    bias_voltage_reg    <= cfg_data[VW-1:0];
                tvc_pkg::CFG_BIAS_RESISTANCE: bias_resistance_reg <= cfg_data[tvc_pkg::BR_W-1:0];
                tvc_pkg::CFG_COEF_A:          coef_a_reg          <= cfg_data;
                tvc_pkg::CFG_COEF_B:          coef_b_reg          <= cfg_data;
                tvc_pkg::CFG_COEF_C:          coef_c_reg          <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Resistance divider: one quotient bit per stage, remainder stays below v.
    always_comb
    begin
        logic [RW-1:0] src_work;
        logic [VW-1:0] src_rem;
        logic [VW-1:0] src_v;
        logic [VW:0]   t;
        for (int k = 0; k < RW; k++)
        begin
            if (k == 0)
            begin
                src_work = {s1_prod_reg, {(RW - tvc_pkg::PROD_W){1'b0}}};
                src_rem  = '0;
                src_v    = s1_v_reg;
            end
            else
            begin
                src_work = dv_work_reg[k-1];
                src_rem  = dv_rem_reg[k-1];
                src_v    = dv_v_reg[k-1];
            end
            t = {src_rem, src_work[RW-1]};
            if (t >= {1'b0, src_v})
            begin
                dv_rem_next[k]  = VW'(t - {1'b0, src_v});
                dv_work_next[k] = {src_work[RW-2:0], 1'b1};
            end
            else
            begin
                dv_rem_next[k]  = t[VW-1:0];
                dv_work_next[k] = {src_work[RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_v_reg    <= sense_voltage;
            s0_diff_reg <= bias_voltage_reg - sense_voltage;
            s1_v_reg    <= s0_v_reg;
            s1_prod_reg <= tvc_pkg::PROD_W'(bias_resistance_reg) * tvc_pkg::PROD_W'(s0_diff_reg);
            dv_v_reg[0] <= s1_v_reg;
            for (int k = 0; k < RW; k++)
            begin
                dv_work_reg[k] <= dv_work_next[k];
                dv_rem_reg[k]  <= dv_rem_next[k];
            end
            for (int k = 1; k < RW; k++)
            begin
                dv_v_reg[k] <= dv_v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_ctl_reg <= '0;
            s1_ctl_reg <= '0;
            for (int k = 0; k < RW; k++)
            begin
                dv_ctl_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            s0_ctl_reg.valid <= in_valid;
            s0_ctl_reg.bad   <= (sense_voltage == '0) || (sense_voltage >= bias_voltage_reg);
            s1_ctl_reg       <= s0_ctl_reg;
            dv_ctl_reg[0]    <= s1_ctl_reg;
            for (int k = 1; k < RW; k++)
            begin
                dv_ctl_reg[k] <= dv_ctl_reg[k-1];
            end
        end
    end

    always_comb
    begin
        lg_ctl_in.valid = dv_ctl_reg[RW-1].valid;
        lg_ctl_in.bad   = dv_ctl_reg[RW-1].bad || (dv_work_reg[RW-1] == '0);
    end

    tvc_log2 #(
        .ITER(LOG_ITERATIONS)
    ) u_log2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .ctl_in  (lg_ctl_in),
        .r       (dv_work_reg[RW-1]),
        .ctl_out (lg_ctl),
        .lneg    (lg_lneg),
        .mag     (lg_mag)
    );

    tvc_mul #(
        .A_W(tvc_pkg::MAG_W), .B_W(tvc_pkg::FRAC_W), .SIDE_W(SIDE_S)
    ) u_mul_ln (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .a(lg_mag), .b(tvc_pkg::LN2_Q48), .side_in({lg_ctl, lg_lneg}),
        .prod(m1_prod), .side_out(m1_side)
    );

    tvc_mul #(
        .A_W(tvc_pkg::L_W), .B_W(tvc_pkg::L_W), .SIDE_W(SIDE_S)
    ) u_mul_sq (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .a(m1_prod[tvc_pkg::L_W-1:0]), .b(m1_prod[tvc_pkg::L_W-1:0]), .side_in(m1_side),
        .prod(m2_prod), .side_out(m2_side)
    );

    tvc_mul #(
        .A_W(tvc_pkg::COEF_W), .B_W(tvc_pkg::L_W), .SIDE_W(tvc_pkg::L_W)
    ) u_mul_b (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .a(coef_b_reg), .b(m1_prod[tvc_pkg::L_W-1:0]), .side_in(m1_prod[tvc_pkg::L_W-1:0]),
        .prod(m3_prod), .side_out(m3_side)
    );

    tvc_mul #(
        .A_W(tvc_pkg::L2_W), .B_W(tvc_pkg::L_W), .SIDE_W(SIDE_L)
    ) u_mul_cube (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .a(m2_prod[tvc_pkg::L2_W-1:0]), .b(m3_side),
        .side_in({m2_side, m3_prod[tvc_pkg::L_W-1:0]}),
        .prod(m4_prod), .side_out(m4_side)
    );

    tvc_mul #(
        .A_W(tvc_pkg::COEF_W), .B_W(tvc_pkg::L3_W), .SIDE_W(SIDE_L)
    ) u_mul_c (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .a(coef_c_reg), .b(m4_prod[tvc_pkg::L3_W-1:0]), .side_in(m4_side),
        .prod(m5_prod), .side_out(m5_side)
    );

    assign m5_ctl  = tvc_pkg::ctl_t'(m5_side[SIDE_L-1 -: 2]);
    assign m5_lneg = m5_side[tvc_pkg::L_W];
    assign sum_bc  = DW'(m5_side[tvc_pkg::L_W-1:0]) + DW'(m5_prod[tvc_pkg::L3_W-1:0]);

    always_comb
    begin
        if (m5_lneg)
        begin
            pos_next = DW'(coef_a_reg);
            neg_next = sum_bc;
        end
        else
        begin
            pos_next = DW'(coef_a_reg) + sum_bc;
            neg_next = '0;
        end
    end

    // Reciprocal divider: the quotient fits 16 bits unless flagged as overflow.
    always_comb
    begin
        logic [DW-1:0]     src_rem;
        logic [TW-1:0]     src_q;
        logic [DW-1:0]     src_d;
        logic [WIDE_W-1:0] dsh;
        for (int i = 0; i < TW; i++)
        begin
            if (i == 0)
            begin
                src_rem = q0_n_reg;
                src_q   = '0;
                src_d   = q0_d_reg;
            end
            else
            begin
                src_rem = qd_rem_reg[i-1];
                src_q   = qd_q_reg[i-1];
                src_d   = qd_d_reg[i-1];
            end
            dsh = WIDE_W'(src_d) << (TW - 1 - i);
            if (WIDE_W'(src_rem) >= dsh)
            begin
                qd_rem_next[i] = src_rem - dsh[DW-1:0];
                qd_q_next[i]   = {src_q[TW-2:0], 1'b1};
            end
            else
            begin
                qd_rem_next[i] = src_rem;
                qd_q_next[i]   = {src_q[TW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sm_d_reg    <= pos_next - neg_next;
            sm_negd_reg <= pos_next < neg_next;
            q0_n_reg    <= tvc_pkg::HUNDRED_Q48 + (sm_d_reg >> 1);
            q0_d_reg    <= sm_d_reg;
            q0_fin_reg.negd <= sm_negd_reg;
            q0_fin_reg.dz   <= sm_d_reg == '0;
            q0_fin_reg.ovf  <= {{TW{1'b0}}, tvc_pkg::HUNDRED_Q48 + (sm_d_reg >> 1)}
                            >= {sm_d_reg, {TW{1'b0}}};
            qd_d_reg[0]   <= q0_d_reg;
            qd_fin_reg[0] <= q0_fin_reg;
            for (int i = 0; i < TW; i++)
            begin
                qd_rem_reg[i] <= qd_rem_next[i];
                qd_q_reg[i]   <= qd_q_next[i];
            end
            for (int i = 1; i < TW; i++)
            begin
                qd_d_reg[i]   <= qd_d_reg[i-1];
                qd_fin_reg[i] <= qd_fin_reg[i-1];
            end
            temp_reg   <= temp_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        if (qd_ctl_reg[TW-1].bad)
        begin
            temp_next   = tvc_pkg::TEMP_ZERO;
            status_next = tvc_pkg::STATUS_INVALID;
        end
        else if (qd_fin_reg[TW-1].negd)
        begin
            temp_next   = tvc_pkg::TEMP_MIN;
            status_next = tvc_pkg::STATUS_SAT;
        end
        else if (qd_fin_reg[TW-1].dz || qd_fin_reg[TW-1].ovf
                 || (qd_q_reg[TW-1] > tvc_pkg::TK_MAX))
        begin
            temp_next   = tvc_pkg::TEMP_MAX;
            status_next = tvc_pkg::STATUS_SAT;
        end
        else
        begin
            temp_next   = $signed(qd_q_reg[TW-1] - tvc_pkg::KELVIN_CENTI);
            status_next = tvc_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_ctl_reg    <= '0;
            q0_ctl_reg    <= '0;
            for (int i = 0; i < TW; i++)
            begin
                qd_ctl_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sm_ctl_reg    <= m5_ctl;
            q0_ctl_reg    <= sm_ctl_reg;
            qd_ctl_reg[0] <= q0_ctl_reg;
            for (int i = 1; i < TW; i++)
            begin
                qd_ctl_reg[i] <= qd_ctl_reg[i-1];
            end
            out_valid_reg <= qd_ctl_reg[TW-1].valid;
        end
    end

    assign out_valid  = out_valid_reg;
    assign temp_centi = temp_reg;
    assign status     = status_reg;

endmodule

[hw/rtl/tvc_mul.sv]
// Three-stage multiplier giving (a*b) >> 48 from four 32x32 partial products.
// Depends on tvc_pkg; carries a sideband vector with the same latency.
module tvc_mul #(
    parameter int A_W    = 64,
    parameter int B_W    = 64,
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [A_W-1:0]              a,
    input  logic [B_W-1:0]              b,
    input  logic [SIDE_W-1:0]           side_in,
    output logic [tvc_pkg::DATA_W-1:0]  prod,
    output logic [SIDE_W-1:0]           side_out
);

    localparam int DW = tvc_pkg::DATA_W;
    localparam int HW = DW / 2;

    logic [DW-1:0]   a_ext;
    logic [DW-1:0]   b_ext;
    logic [DW-1:0]   ll_reg;
    logic [DW-1:0]   hl_reg;
    logic [DW-1:0]   lh_reg;
    logic [DW-1:0]   hh_reg;
    logic [DW:0]     mid_reg;
    logic [DW-1:0]   lo_reg;
    logic [DW-1:0]   hi_reg;
    logic [2*DW-1:0] sum_next;
    logic [DW-1:0]   prod_reg;
    logic [SIDE_W-1:0] side1_reg;
    logic [SIDE_W-1:0] side2_reg;
    logic [SIDE_W-1:0] side3_reg;

    assign a_ext = DW'(a);
    assign b_ext = DW'(b);

    assign sum_next = {hi_reg, {DW{1'b0}}}
                    + {{(HW-1){1'b0}}, mid_reg, {HW{1'b0}}}
                    + {{DW{1'b0}}, lo_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg   <= DW'(a_ext[HW-1:0]) * DW'(b_ext[HW-1:0]);
            hl_reg   <= DW'(a_ext[DW-1:HW]) * DW'(b_ext[HW-1:0]);
            lh_reg   <= DW'(a_ext[HW-1:0]) * DW'(b_ext[DW-1:HW]);
            hh_reg   <= DW'(a_ext[DW-1:HW]) * DW'(b_ext[DW-1:HW]);
            mid_reg  <= {1'b0, hl_reg} + {1'b0, lh_reg};
            lo_reg   <= ll_reg;
            hi_reg   <= hh_reg;
            prod_reg <= sum_next[tvc_pkg::FRAC_W +: DW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side1_reg <= '0;
            side2_reg <= '0;
            side3_reg <= '0;
        end
        else if (en)
        begin
            side1_reg <= side_in;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
        end
    end

    assign prod     = prod_reg;
    assign side_out = side3_reg;

endmodule

[hw/rtl/tvc_log2.sv]
// Pipelined base-2 logarithm: staged normalizing shift, one squaring per stage,
// then the signed result folded to magnitude and sign. Depends on tvc_pkg.
module tvc_log2 #(
    parameter int ITER = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  tvc_pkg::ctl_t              ctl_in,
    input  logic [tvc_pkg::R_W-1:0]    r,
    output tvc_pkg::ctl_t              ctl_out,
    output logic                       lneg,
    output logic [tvc_pkg::MAG_W-1:0]  mag
);

    localparam int RW     = tvc_pkg::R_W;
    localparam int SW     = tvc_pkg::SH_W;
    localparam int FW     = tvc_pkg::FRAC_W;
    localparam int NORM_N = $clog2(RW);
    localparam int M_W    = 31;

    logic [RW-1:0]    n_reg   [NORM_N];
    logic [RW-1:0]    n_next  [NORM_N];
    logic [SW-1:0]    sh_reg  [NORM_N];
    logic [SW-1:0]    sh_next [NORM_N];
    tvc_pkg::ctl_t    nctl_reg[NORM_N];

    logic [M_W-1:0]   m_reg   [ITER];
    logic [M_W-1:0]   m_next  [ITER];
    logic [ITER-1:0]  f_reg   [ITER];
    logic [ITER-1:0]  f_next  [ITER];
    logic [SW-1:0]    p_reg   [ITER];
    logic [SW-1:0]    p_next  [ITER];
    tvc_pkg::ctl_t    sctl_reg[ITER];

    logic [tvc_pkg::MAG_W-1:0] mag_reg;
    logic [tvc_pkg::MAG_W-1:0] mag_next;
    logic                      lneg_reg;
    logic                      lneg_next;
    tvc_pkg::ctl_t             ctl_out_reg;

    always_comb
    begin
        logic [RW-1:0] src;
        logic [SW-1:0] src_sh;
        int            shamt;
        for (int i = 0; i < NORM_N; i++)
        begin
            if (i == 0)
            begin
                src    = r;
                src_sh = '0;
            end
            else
            begin
                src    = n_reg[i-1];
                src_sh = sh_reg[i-1];
            end
            shamt = 1 << (NORM_N - 1 - i);
            if ((src >> (RW - shamt)) == '0)
            begin
                n_next[i]  = src << shamt;
                sh_next[i] = src_sh + SW'(shamt);
            end
            else
            begin
                n_next[i]  = src;
                sh_next[i] = src_sh;
            end
        end
    end

    always_comb
    begin
        logic [M_W-1:0]   src_m;
        logic [ITER-1:0]  src_f;
        logic [SW-1:0]    src_p;
        logic [2*M_W-1:0] sq;
        logic [M_W:0]     t;
        for (int i = 0; i < ITER; i++)
        begin
            if (i == 0)
            begin
                src_m = n_reg[NORM_N-1][RW-1 -: M_W];
                src_f = '0;
                src_p = SW'(RW - 1) - sh_reg[NORM_N-1];
            end
            else
            begin
                src_m = m_reg[i-1];
                src_f = f_reg[i-1];
                src_p = p_reg[i-1];
            end
            sq = (2*M_W)'(src_m) * (2*M_W)'(src_m);
            t  = sq[2*M_W-1 -: M_W+1];
            if (t[M_W])
            begin
                m_next[i] = t[M_W:1];
                f_next[i] = {src_f[ITER-2:0], 1'b1};
            end
            else
            begin
                m_next[i] = t[M_W-1:0];
                f_next[i] = {src_f[ITER-2:0], 1'b0};
            end
            p_next[i] = src_p;
        end
    end

    always_comb
    begin
        logic [SW-1:0] pl;
        logic [FW-1:0] f48;
        pl  = p_reg[ITER-1];
        f48 = FW'(f_reg[ITER-1]) << (FW - ITER);
        if (pl >= SW'(tvc_pkg::R_FRAC))
        begin
            mag_next  = {SW'(pl - SW'(tvc_pkg::R_FRAC)), f48};
            lneg_next = 1'b0;
        end
        else
        begin
            mag_next  = {SW'(SW'(tvc_pkg::R_FRAC) - pl), {FW{1'b0}}}
                      - tvc_pkg::MAG_W'(f48);
            lneg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NORM_N; i++)
            begin
                n_reg[i]  <= n_next[i];
                sh_reg[i] <= sh_next[i];
            end
            for (int i = 0; i < ITER; i++)
            begin
                m_reg[i] <= m_next[i];
                f_reg[i] <= f_next[i];
                p_reg[i] <= p_next[i];
            end
            mag_reg  <= mag_next;
            lneg_reg <= lneg_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NORM_N; i++)
            begin
                nctl_reg[i] <= '0;
            end
            for (int i = 0; i < ITER; i++)
            begin
                sctl_reg[i] <= '0;
            end
            ctl_out_reg <= '0;
        end
        else if (en)
        begin
            nctl_reg[0] <= ctl_in;
            for (int i = 1; i < NORM_N; i++)
            begin
                nctl_reg[i] <= nctl_reg[i-1];
            end
            sctl_reg[0] <= nctl_reg[NORM_N-1];
            for (int i = 1; i < ITER; i++)
            begin
                sctl_reg[i] <= sctl_reg[i-1];
            end
            ctl_out_reg <= sctl_reg[ITER-1];
        end
    end

    assign ctl_out = ctl_out_reg;
    assign lneg    = lneg_reg;
    assign mag     = mag_reg;

endmodule

[hw/rtl/tvc_checker.sv]
// Port-level checks of the thermistor converter, bound to its top level.
// Depends on tvc_pkg and thermistor_voltage_to_celsius_defines.svh.
`include "thermistor_voltage_to_celsius_defines.svh"

module tvc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [tvc_pkg::TEMP_W-1:0]  temp_centi,
    input logic [tvc_pkg::STATUS_W-1:0]       status
);

    `TVC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(temp_centi) && $stable(status), "stalled result beat changed")
    `TVC_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "input stalled with empty output")
    `TVC_ASSERT_IMP(a_invalid_zero, clk, rst_n, out_valid && (status == tvc_pkg::STATUS_INVALID), temp_centi == tvc_pkg::TEMP_ZERO, "invalid status with nonzero temperature")
    `TVC_ASSERT_IMP(a_sat_rail, clk, rst_n, out_valid && (status == tvc_pkg::STATUS_SAT), (temp_centi == tvc_pkg::TEMP_MAX) || (temp_centi == tvc_pkg::TEMP_MIN), "saturated result off the rails")

endmodule

bind thermistor_voltage_to_celsius tvc_checker u_tvc_checker (.*);

[tb/sv/thermistor_voltage_to_celsius_checker.sv]
// Checker for the thermistor converter: tracks register writes, predicts each result.
// Compares result beats in order against the predictions; depends on tvc_pkg.
`timescale 1ns / 100ps
module thermistor_voltage_to_celsius_checker #(
    parameter int LOG_ITERATIONS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [tvc_pkg::V_W-1:0]           sense_voltage,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [tvc_pkg::TEMP_W-1:0] temp_centi,
    input  logic [tvc_pkg::STATUS_W-1:0]      status,
    input  logic                              cfg_we,
    input  logic [tvc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tvc_pkg::COEF_W-1:0]        cfg_data,
    output int                                failures,
    output int                                pending,
    output int                                results_seen
);

    typedef struct packed {
        logic signed [tvc_pkg::TEMP_W-1:0] temp;
        logic [tvc_pkg::STATUS_W-1:0]      stat;
    } reading_t;

    logic [tvc_pkg::V_W-1:0]    bias_v;
    logic [tvc_pkg::BR_W-1:0]   bias_r;
    logic [tvc_pkg::COEF_W-1:0] coef_a, coef_b, coef_c;
    reading_t                   readings_due[$];

    function automatic logic [63:0] mul_frac(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = 128'(a) * 128'(b);
        return prod[111:48];
    endfunction

    function automatic longint log2_frac(input logic [63:0] r);
        int          p;
        logic [63:0] m;
        logic [63:0] frac;
        p = 63;
        frac = '0;
        while (p > 0 && !r[p])
            p--;
        if (p >= 30)
            m = r >> (p - 30);
        else
            m = r << (30 - p);
        for (int i = 0; i < LOG_ITERATIONS; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return longint'(p - 24) * (64'sd1 <<< 48) + longint'(frac << (48 - LOG_ITERATIONS));
    endfunction

    function automatic reading_t convert_voltage(input logic [tvc_pkg::V_W-1:0] v);
        reading_t    res;
        logic [63:0] r, mag, l, l2, l3, bl, cl, pos, neg, d, tk;
        longint      lg;
        if (v == '0 || v >= bias_v)
            return '{tvc_pkg::TEMP_ZERO, tvc_pkg::STATUS_INVALID};
        r = ((64'(bias_r) * 64'(bias_v - v)) << 24) / 64'(v);
        if (r == '0)
            return '{tvc_pkg::TEMP_ZERO, tvc_pkg::STATUS_INVALID};
        lg = log2_frac(r);
        mag = (lg < 0) ? 64'(-lg) : 64'(lg);
        l = mul_frac(mag, 64'(tvc_pkg::LN2_Q48));
        l2 = mul_frac(l, l);
        l3 = mul_frac(l2, l);
        bl = mul_frac(64'(coef_b), l);
        cl = mul_frac(64'(coef_c), l3);
        pos = 64'(coef_a);
        neg = '0;
        if (lg < 0)
            neg = bl + cl;
        else
            pos = pos + bl + cl;
        if (pos < neg)
            return '{tvc_pkg::TEMP_MIN, tvc_pkg::STATUS_SAT};
        d = pos - neg;
        if (d == '0)
            return '{tvc_pkg::TEMP_MAX, tvc_pkg::STATUS_SAT};
        tk = (tvc_pkg::HUNDRED_Q48 + d / 2) / d;
        if (tk > 64'(tvc_pkg::TK_MAX))
            return '{tvc_pkg::TEMP_MAX, tvc_pkg::STATUS_SAT};
        res.temp = tvc_pkg::TEMP_W'(tk - 64'(tvc_pkg::KELVIN_CENTI));
        res.stat = tvc_pkg::STATUS_OK;
        return res;
    endfunction

    assign pending = readings_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            bias_v = tvc_pkg::BIAS_VOLTAGE_RESET;
            bias_r = tvc_pkg::BIAS_RESISTANCE_RESET;
            coef_a = tvc_pkg::COEF_A_RESET;
            coef_b = tvc_pkg::COEF_B_RESET;
            coef_c = tvc_pkg::COEF_C_RESET;
            readings_due.delete();
            failures = 0;
            results_seen = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (readings_due.size() == 0)
                begin
                    $display("%0t: result beat with none expected: temp %0d status %0d",
                             $time, temp_centi, status);
                    failures++;
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (temp_centi !== want.temp)
                    begin
                        $display("%0t: temp_centi expected %0d actual %0d",
                                 $time, want.temp, temp_centi);
                        failures++;
                    end
                    if (status !== want.stat)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.stat, status);
                        failures++;
                    end
                end
            end
            if (in_valid && in_ready)
                readings_due.push_back(convert_voltage(sense_voltage));
            if (cfg_we)
            begin
                case (cfg_index)
                    tvc_pkg::CFG_BIAS_VOLTAGE:    bias_v = cfg_data[tvc_pkg::V_W-1:0];
                    tvc_pkg::CFG_BIAS_RESISTANCE: bias_r = cfg_data[tvc_pkg::BR_W-1:0];
                    tvc_pkg::CFG_COEF_A:          coef_a = cfg_data;
                    tvc_pkg::CFG_COEF_B:          coef_b = cfg_data;
                    tvc_pkg::CFG_COEF_C:          coef_c = cfg_data;
                    default:                      ;
                endcase
            end
        end
    end
endmodule

[tb/sv/thermistor_voltage_to_celsius_test.sv]
// Top of the thermistor converter testbench: clock, reset, register phases and stimulus.
// Depends on tvc_pkg, the block and thermistor_voltage_to_celsius_checker.
`timescale 1ns / 100ps
module thermistor_voltage_to_celsius_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 200;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [tvc_pkg::V_W-1:0]           sense_voltage = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic signed [tvc_pkg::TEMP_W-1:0] temp_centi;
    logic [tvc_pkg::STATUS_W-1:0]      status;
    logic                              cfg_we = 1'b0;
    logic [tvc_pkg::CFG_IDX_W-1:0]     cfg_index = tvc_pkg::CFG_BIAS_VOLTAGE;
    logic [tvc_pkg::COEF_W-1:0]        cfg_data = '0;
    int                                failures, pending, results_seen;
    int                                cycles = 0;
    int                                beats_sent = 0;
    int                                phases = 0;
    int                                burst_left = 0;
    logic [tvc_pkg::V_W-1:0]           bias_now = tvc_pkg::BIAS_VOLTAGE_RESET;
    int                                stall_mode = 0;

    thermistor_voltage_to_celsius uut (.*);

    thermistor_voltage_to_celsius_checker chk (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL thermistor_voltage_to_celsius");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (cycles % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 1);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic write_reg(input logic [tvc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tvc_pkg::COEF_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == tvc_pkg::CFG_BIAS_VOLTAGE)
            bias_now = value[tvc_pkg::V_W-1:0];
    endtask

    task automatic set_regs(input logic [tvc_pkg::V_W-1:0] bv,
                            input logic [tvc_pkg::BR_W-1:0] br,
                            input logic [tvc_pkg::COEF_W-1:0] a,
                            input logic [tvc_pkg::COEF_W-1:0] b,
                            input logic [tvc_pkg::COEF_W-1:0] c);
        write_reg(tvc_pkg::CFG_BIAS_VOLTAGE, tvc_pkg::COEF_W'(bv));
        write_reg(tvc_pkg::CFG_BIAS_RESISTANCE, tvc_pkg::COEF_W'(br));
        write_reg(tvc_pkg::CFG_COEF_A, a);
        write_reg(tvc_pkg::CFG_COEF_B, b);
        write_reg(tvc_pkg::CFG_COEF_C, c);
        phases++;
    endtask

    task automatic send_voltage(input logic [tvc_pkg::V_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        sense_voltage <= v;
        do
            @(posedge clk);
        while (!in_ready);
        beats_sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [tvc_pkg::V_W-1:0] pick_voltage;
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return bias_now;
        if (sel == 2)
            return tvc_pkg::V_W'($urandom);
        if (sel == 3 && bias_now > 2)
            return bias_now - tvc_pkg::V_W'($urandom_range(1, 3));
        if (bias_now > 1)
            return tvc_pkg::V_W'($urandom_range(1, bias_now - 1));
        return tvc_pkg::V_W'($urandom);
    endfunction

    task automatic random_run(input int count);
        repeat (count) send_voltage(pick_voltage());
    endtask

    initial
    begin
        logic [tvc_pkg::V_W-1:0] directed[$];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{19'd0, 19'd1, 19'd2, 19'd65536, 19'd163840, 19'd163841, 19'd300000,
                     19'd327679, 19'd327680, 19'd327681, 19'h2AAAA, 19'h55555, 19'h7FFFF,
                     19'd1000, 19'd20000};
        foreach (directed[i])
            send_voltage(directed[i]);
        random_run(300);
        drain();

        set_regs(19'h7FFFF, 20'hFFFFF, tvc_pkg::COEF_A_RESET, tvc_pkg::COEF_B_RESET,
                 tvc_pkg::COEF_C_RESET);
        send_voltage(19'd1);
        send_voltage(19'h7FFFE);
        send_voltage(19'h7FFFF);
        random_run(150);
        drain();

        set_regs(19'd1, 20'd1, tvc_pkg::COEF_A_RESET, tvc_pkg::COEF_B_RESET,
                 tvc_pkg::COEF_C_RESET);
        random_run(20);
        drain();

        set_regs(tvc_pkg::BIAS_VOLTAGE_RESET, 20'd0, tvc_pkg::COEF_A_RESET,
                 tvc_pkg::COEF_B_RESET, tvc_pkg::COEF_C_RESET);
        random_run(20);
        drain();

        set_regs(tvc_pkg::BIAS_VOLTAGE_RESET, tvc_pkg::BIAS_RESISTANCE_RESET,
                 48'd0, 48'd0, 48'd0);
        random_run(30);
        drain();

        set_regs(19'h7FFFF, 20'd1, 48'd0, tvc_pkg::COEF_B_RESET, tvc_pkg::COEF_C_RESET);
        random_run(120);
        drain();

        set_regs(tvc_pkg::BIAS_VOLTAGE_RESET, 20'd1, tvc_pkg::COEF_A_RESET,
                 48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF);
        random_run(100);
        drain();

        set_regs(19'h7FFFF, 20'hFFFFF, 48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF);
        random_run(100);
        drain();

        repeat (6)
        begin
            set_regs(tvc_pkg::V_W'($urandom), tvc_pkg::BR_W'($urandom),
                     tvc_pkg::COEF_W'({$urandom, $urandom} >> $urandom_range(0, 40)),
                     tvc_pkg::COEF_W'({$urandom, $urandom} >> $urandom_range(0, 40)),
                     tvc_pkg::COEF_W'({$urandom, $urandom} >> $urandom_range(0, 48)));
            random_run(80);
            drain();
        end

        $display("Sent %0d voltage beats over %0d register settings plus reset values;",
                 beats_sent, phases);
        $display("checked %0d result beats covering ok, invalid and saturated cases.",
                 results_seen);
        if (failures == 0)
            $display("PASS thermistor_voltage_to_celsius");
        else
            $display("FAIL thermistor_voltage_to_celsius");
        $finish;
    end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/tvc_pkg.sv
hw/rtl/tvc_mul.sv
hw/rtl/tvc_log2.sv
hw/rtl/thermistor_voltage_to_celsius.sv
hw/rtl/tvc_checker.sv
tb/sv/thermistor_voltage_to_celsius_checker.sv
tb/sv/thermistor_voltage_to_celsius_test.sv
